// File: rtl/core/ffn_pkg.sv
// Package: shared types and constants for the flat-field normaliser.
`timescale 1ns / 1ps
`default_nettype none
package ffn_pkg;
  localparam int unsigned ROWS_DEF = 512;
  localparam int unsigned COLS_DEF = 512;
  localparam int unsigned PIXEL_BITS_DEF = 16;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned IDX_W = 18;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned OUT_W = 32;

  localparam logic [1:0] MODE_PROC = 2'd0;
  localparam logic [1:0] MODE_LD_I = 2'd1;
  localparam logic [1:0] MODE_LD_G = 2'd2;
  localparam logic [1:0] MODE_LD_O = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] pixel_index;
    logic [VAL_W-1:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normalized_value;
    logic                    divide_error;
  } out_word_t;
endpackage
`default_nettype wire

// File: rtl/core/ffn_div_cell.sv
// Divider cell: one restoring-division step on a word moving down the chain.
`timescale 1ns / 1ps
`default_nettype none
module ffn_div_cell #(
  parameter int unsigned NUM_W = 41,
  parameter int unsigned DEN_W = 17,
  parameter int unsigned STEP  = 0
) (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             vld_i,
  input  wire  logic [NUM_W-1:0] num_i,
  input  wire  logic [DEN_W-1:0] den_i,
  input  wire  logic [DEN_W:0]   rem_i,
  input  wire  logic             neg_i,
  input  wire  logic             err_i,
  output logic                   vld_o,
  output logic [NUM_W-1:0]       num_o,
  output logic [DEN_W-1:0]       den_o,
  output logic [DEN_W:0]         rem_o,
  output logic                   neg_o,
  output logic                   err_o
);
  logic [DEN_W+1:0] trial;
  logic [DEN_W:0]   rem_d;
  logic [NUM_W-1:0] num_d;
  logic             qbit;

  // shift in next numerator bit and try subtracting
  always_comb begin
    trial = {rem_i, num_i[NUM_W-1-STEP]};
    qbit  = (trial >= {1'b0, 1'b0, den_i});
    rem_d = qbit ? (DEN_W+1)'(trial - {2'b00, den_i}) : trial[DEN_W:0];
    // quotient bit replaces the numerator bit just consumed
    num_d = num_i;
    num_d[NUM_W-1-STEP] = qbit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_o <= 1'b0;
    else         vld_o <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    num_o <= num_d;
    den_o <= den_i;
    rem_o <= rem_d;
    neg_o <= neg_i;
    err_o <= err_i;
  end
endmodule
`default_nettype wire

// File: rtl/core/flat_field_normalizer_unit.sv
// Top level: reference maps, operand stage, divider cell chain and output stage.
//
// Channel  | Direction | Handshake        | Payload
// input    | in        | start_i / busy_o | in_i  (ffn_pkg::in_word_t)
// result   | out       | strobe_o         | res_o (ffn_pkg::out_word_t)
//
// One word is taken every cycle; busy_o is always low. A process word passes the
// memory read register, which loads at the accepting edge, then the operand stage,
// one divider cell per quotient bit (PIXEL_BITS+FRACTION_BITS+1 cells) and the
// rounding and saturation stage, which registers its result on res_o.
// Load words give nothing. The maps have no reset.
// The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module flat_field_normalizer_unit #(
  parameter int unsigned ROWS          = ffn_pkg::ROWS_DEF,
  parameter int unsigned COLS          = ffn_pkg::COLS_DEF,
  parameter int unsigned PIXEL_BITS    = ffn_pkg::PIXEL_BITS_DEF,
  parameter int unsigned FRACTION_BITS = ffn_pkg::FRACTION_BITS_DEF
) (
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  logic              start_i,
  input  wire  ffn_pkg::in_word_t in_i,
  output logic                    busy_o,
  output logic                    strobe_o,
  output ffn_pkg::out_word_t      res_o
);
  localparam int unsigned DEPTH = ROWS * COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW    = PIXEL_BITS;
  localparam int unsigned DW    = PW + 1;                  // denominator, positive
  // magnitude of n is at most 2^PW-1; one extra bit for rounding (2q form)
  localparam int unsigned NW    = PW + FRACTION_BITS + 1;
  localparam int unsigned OW    = ffn_pkg::OUT_W;

  assign busy_o = 1'b0;

  // input decode
  logic          acc;
  logic          ok;
  logic [PW-1:0] val;
  assign acc = start_i;
  assign ok  = (18'(in_i.pixel_index) < 18'(DEPTH)) || (DEPTH >= 262144);
  always_comb begin
    val = '0;
    for (int b = 0; b < PW; b++) val[b] = (b < ffn_pkg::VAL_W) ? in_i.pixel_value[b] : 1'b0;
  end

  // reference maps
  logic [PW-1:0] imap [DEPTH];
  logic [PW-1:0] gmap [DEPTH];
  logic [PW-1:0] omap [DEPTH];
  logic [AW-1:0] addr;
  assign addr = AW'(in_i.pixel_index);

  logic [PW-1:0] i_rd_q, g_rd_q, o_rd_q;
  always_ff @(posedge clk_i) begin
    if (acc && ok && in_i.mode == ffn_pkg::MODE_LD_I) imap[addr] <= val;
    if (acc && ok && in_i.mode == ffn_pkg::MODE_LD_G) gmap[addr] <= val;
    if (acc && ok && in_i.mode == ffn_pkg::MODE_LD_O) omap[addr] <= val;
    i_rd_q <= imap[addr];
    g_rd_q <= gmap[addr];
    o_rd_q <= omap[addr];
  end

  // read stage pipeline control
  logic          rv_q, rok_q;
  logic [PW-1:0] rval_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else         rv_q <= acc && (in_i.mode == ffn_pkg::MODE_PROC);
  end
  always_ff @(posedge clk_i) begin
    rok_q  <= ok;
    rval_q <= val;
  end

  // operand stage: n = R - G, d = O - I
  logic          ov_q;
  logic [PW-1:0] nmag_q;
  logic [DW-1:0] den_q;
  logic          neg_q, err_q;
  logic signed [PW+1:0] n_s, d_s;
  always_comb begin
    n_s = $signed({2'b00, rval_q}) - $signed({2'b00, rok_q ? g_rd_q : {PW{1'b0}}});
    d_s = rok_q ? ($signed({2'b00, o_rd_q}) - $signed({2'b00, i_rd_q})) : '0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else         ov_q <= rv_q;
  end
  always_ff @(posedge clk_i) begin
    neg_q  <= n_s[PW+1];
    nmag_q <= PW'(n_s[PW+1] ? -n_s : n_s);
    err_q  <= (d_s <= 0);
    den_q  <= (d_s <= 0) ? DW'(1) : DW'(d_s);
  end

  // divider chain: quotient of mag * 2^(F+1) / d, one bit per cell
  logic          cv   [NW+1];
  logic [NW-1:0] cnum [NW+1];
  logic [DW-1:0] cden [NW+1];
  logic [DW:0]   crem [NW+1];
  logic          cneg [NW+1];
  logic          cerr [NW+1];

  assign cv[0]   = ov_q;
  assign cnum[0] = {nmag_q, {(NW-PW){1'b0}}};
  assign cden[0] = den_q;
  assign crem[0] = '0;
  assign cneg[0] = neg_q;
  assign cerr[0] = err_q;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    ffn_div_cell #(.NUM_W(NW), .DEN_W(DW), .STEP(k)) u_cell (
      .clk_i, .rst_ni,
      .vld_i(cv[k]),   .num_i(cnum[k]),   .den_i(cden[k]),
      .rem_i(crem[k]), .neg_i(cneg[k]),   .err_i(cerr[k]),
      .vld_o(cv[k+1]), .num_o(cnum[k+1]), .den_o(cden[k+1]),
      .rem_o(crem[k+1]), .neg_o(cneg[k+1]), .err_o(cerr[k+1])
    );
  end

  // rounding (half up on 2q form), sign and saturation
  logic [NW-1:0]  q;
  logic [OW-1:0]  res_d;
  assign q = (cnum[NW] >> 1) + NW'(cnum[NW][0]);
  always_comb begin
    if (cerr[NW]) res_d = '0;
    else if (cneg[NW]) res_d = (q > NW'(64'h8000_0000)) ? 32'h8000_0000 : OW'(-q);
    else res_d = (q > NW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : OW'(q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strobe_o <= 1'b0;
    else         strobe_o <= cv[NW];
  end
  always_ff @(posedge clk_i) begin
    res_o.normalized_value <= res_d;
    res_o.divide_error     <= cerr[NW];
  end
endmodule
`default_nettype wire

// File: tb/sv/tb_flat_field_normalizer_unit.sv
// Testbench: loads the three reference maps and checks calibrated pixels against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_flat_field_normalizer_unit;
  import ffn_pkg::*;

  localparam int unsigned LATENCY    = PIXEL_BITS_DEF + FRACTION_BITS_DEF + 3;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned N_RANDOM   = 950;
  localparam int unsigned POOL_SIZE  = 24;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  in_word_t  in_i;
  logic      busy_o;
  logic      strobe_o;
  out_word_t res_o;

  flat_field_normalizer_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .in_i    (in_i),
    .busy_o  (busy_o),
    .strobe_o(strobe_o),
    .res_o   (res_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0; #6;
    clk_i = 1'b1; #6;
  end

  // Shadow copies of the maps, only entries that were written
  logic [VAL_W-1:0] instr_map[int unsigned];
  logic [VAL_W-1:0] gel_map[int unsigned];
  logic [VAL_W-1:0] oxa_map[int unsigned];

  out_word_t   pending_pixels[$];
  int unsigned n_errors;
  int unsigned idle_cycles;

  // Directed stimulus row: expected result typed in where obvious
  typedef struct {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  val;
    bit                typed;
    logic signed [31:0] exp_val;
    logic              exp_err;
  } stim_row_t;

  localparam logic [IDX_W-1:0] TOP_IDX = '1;

  stim_row_t dir_table[] = '{
    '{MODE_LD_I, 0, 16'h0000, 0, 0, 0},
    '{MODE_LD_G, 0, 16'h0000, 0, 0, 0},
    '{MODE_LD_O, 0, 16'h0000, 0, 0, 0},
    '{MODE_PROC, 0, 16'h0000, 1, 0, 1},            // zero denominator
    '{MODE_LD_O, 0, 16'hFFFF, 0, 0, 0},
    '{MODE_PROC, 0, 16'hFFFF, 1, 32'h0001_0000, 0}, // exactly one
    '{MODE_PROC, 0, 16'h0000, 1, 0, 0},
    '{MODE_PROC, 0, 16'h1234, 0, 0, 0},
    '{MODE_LD_I, TOP_IDX, 16'h0000, 0, 0, 0},
    '{MODE_LD_G, TOP_IDX, 16'hFFFF, 0, 0, 0},
    '{MODE_LD_O, TOP_IDX, 16'h0001, 0, 0, 0},
    '{MODE_PROC, TOP_IDX, 16'h0000, 1, 32'h8000_0000, 0}, // negative saturation
    '{MODE_LD_I, 1, 16'h0000, 0, 0, 0},
    '{MODE_LD_G, 1, 16'h0000, 0, 0, 0},
    '{MODE_LD_O, 1, 16'h0001, 0, 0, 0},
    '{MODE_PROC, 1, 16'hFFFF, 1, 32'h7FFF_FFFF, 0}, // positive saturation
    '{MODE_LD_I, 2, 16'hFFFF, 0, 0, 0},
    '{MODE_LD_G, 2, 16'h0000, 0, 0, 0},
    '{MODE_LD_O, 2, 16'h0000, 0, 0, 0},
    '{MODE_PROC, 2, 16'h8000, 1, 0, 1},            // negative denominator
    '{MODE_LD_I, 3, 16'h0000, 0, 0, 0},
    '{MODE_LD_G, 3, 16'h0000, 0, 0, 0},
    '{MODE_LD_O, 3, 16'h0003, 0, 0, 0},
    '{MODE_PROC, 3, 16'h0001, 0, 0, 0},            // rounding
    '{MODE_LD_O, 3, 16'h0002, 0, 0, 0},
    '{MODE_PROC, 3, 16'h0001, 0, 0, 0}             // exactly one half, no rounding tie
  };

  // Calibrated pixel: (R-G)/(O-I), 16 fraction bits, rounded and saturated
  function automatic out_word_t calibrate(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] raw);
    longint    num;
    longint    den;
    longint    mag;
    longint    quo;
    out_word_t w;
    num = longint'(raw) - longint'(gel_map[idx]);
    den = longint'(oxa_map[idx]) - longint'(instr_map[idx]);
    w.divide_error     = 1'b0;
    w.normalized_value = '0;
    if (den <= 0) begin
      w.divide_error = 1'b1;
    end else begin
      mag = (num < 0) ? -num : num;
      quo = ((mag << FRACTION_BITS_DEF) + den / 2) / den;
      if (num < 0) begin
        if (quo > 64'sd2147483648) quo = 64'sd2147483648;
        quo = -quo;
      end else if (quo > 64'sd2147483647) begin
        quo = 64'sd2147483647;
      end
      w.normalized_value = quo[31:0];
    end
    return w;
  endfunction

  function automatic bit pixel_ready(logic [IDX_W-1:0] idx);
    return instr_map.exists(idx) && gel_map.exists(idx) && oxa_map.exists(idx);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Present one word and wait until it is taken; update shadow maps or queue a result
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o);
    case (w.mode)
      MODE_LD_I: instr_map[w.pixel_index] = w.pixel_value;
      MODE_LD_G: gel_map[w.pixel_index]   = w.pixel_value;
      MODE_LD_O: oxa_map[w.pixel_index]   = w.pixel_value;
      default: begin
        pending_pixels = {pending_pixels,
                          (typed ? typed_res : calibrate(w.pixel_index, w.pixel_value))};
      end
    endcase
  endtask

  task automatic idle_gap(int unsigned n);
    if (n != 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && strobe_o) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected word", res_o.normalized_value, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (res_o.normalized_value !== want.normalized_value)
          report("normalized_value", res_o.normalized_value, want.normalized_value);
        if (res_o.divide_error !== want.divide_error)
          report("divide_error", 32'(res_o.divide_error), 32'(want.divide_error));
      end
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || strobe_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_flat_field_normalizer_unit: FAIL");
      $finish;
    end
  end

  initial begin
    logic [IDX_W-1:0] pool[POOL_SIZE];
    in_word_t         w;
    out_word_t        r;
    bit               no_gaps;
    int unsigned      k;
    int               lo;
    n_errors    = 0;
    idle_cycles = 0;
    start_i     = 1'b0;
    in_i        = '0;
    rst_ni      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    foreach (dir_table[i]) begin
      w.mode             = dir_table[i].mode;
      w.pixel_index      = dir_table[i].idx;
      w.pixel_value      = dir_table[i].val;
      r.normalized_value = dir_table[i].exp_val;
      r.divide_error     = dir_table[i].exp_err;
      send_word(w, dir_table[i].typed, r);
      idle_gap($urandom_range(0, 3));
    end

    // Random part over a small set of pixel positions
    pool[0] = '0;
    pool[1] = TOP_IDX;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = IDX_W'($urandom_range(0, 262143));
    no_gaps = 1'b0;
    r       = '0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      w.pixel_index = pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 7))
        0:       w.pixel_value = 16'h0000;
        1:       w.pixel_value = 16'hFFFF;
        default: w.pixel_value = VAL_W'($urandom);
      endcase
      if (pixel_ready(w.pixel_index) && $urandom_range(0, 9) < 6) begin
        w.mode = MODE_PROC;
      end else begin
        k = $urandom_range(1, 3);
        w.mode = (k == 1) ? MODE_LD_I : (k == 2) ? MODE_LD_G : MODE_LD_O;
        // small or nonpositive denominators now and then
        if (w.mode == MODE_LD_O && instr_map.exists(w.pixel_index)
            && $urandom_range(0, 2) == 0) begin
          lo = int'(instr_map[w.pixel_index]) + $urandom_range(0, 4) - 1;
          if (lo < 0) lo = 0;
          if (lo > 65535) lo = 65535;
          w.pixel_value = lo[VAL_W-1:0];
        end
      end
      send_word(w, 1'b0, r);
      idle_gap(no_gaps ? 0 : $urandom_range(0, 11));
    end
    start_i <= 1'b0;

    // Drain
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb_flat_field_normalizer_unit: PASS");
    end else begin
      $display("tb_flat_field_normalizer_unit: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
